FILE: src/cbbd_pkg.sv
// Package: shared types, constants and helpers for the cartridge bank and bus decoder.
package cbbd_pkg;

  localparam int BANK_BITS = 7;

  typedef enum logic [3:0] {
    RGN_ROM0   = 4'd0,
    RGN_ROMX   = 4'd1,
    RGN_VRAM   = 4'd2,
    RGN_EXTRAM = 4'd3,
    RGN_WRAM   = 4'd4,
    RGN_OAM    = 4'd5,
    RGN_IO     = 4'd6,
    RGN_HRAM   = 4'd7,
    RGN_IE     = 4'd8,
    RGN_UNUSED = 4'd9
  } region_t;

  localparam logic [1:0] MODE_OAM_SCAN = 2'd2;
  localparam logic [1:0] MODE_DRAWING  = 2'd3;

  localparam logic [15:0] ADDR_DIV = 16'hFF04;
  localparam logic [15:0] ADDR_IE  = 16'hFFFF;

  typedef struct packed {
    logic        wr;
    logic [15:0] addr;
    logic [7:0]  val;
    logic [1:0]  mode;
  } item_t;

  typedef struct packed {
    logic        ram_on;
    logic [6:0]  bank_now;
    logic [7:0]  store_value;
    logic        allowed;
    logic [20:0] rom_addr;
    logic [15:0] local_addr;
    logic [3:0]  region;
  } result_t;

  localparam int OUT_BITS = $bits(result_t);
  localparam int OUT_BYTES_BITS = ((OUT_BITS + 7) / 8) * 8;

  function automatic logic is_mbc1(input logic [7:0] t);
    return (t >= 8'h01) && (t <= 8'h03);
  endfunction

  function automatic logic is_mbc2(input logic [7:0] t);
    return (t == 8'h05) || (t == 8'h06);
  endfunction

  function automatic logic is_mbc3(input logic [7:0] t);
    return (t >= 8'h0F) && (t <= 8'h13);
  endfunction

endpackage

FILE: src/cbbd_bank_ctrl.sv
// Bank controller: ROM bank and external RAM enable state with write rules.
module cbbd_bank_ctrl
  import cbbd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  item_t                item,
  input  logic [7:0]           cart_type,
  output logic [BANK_BITS-1:0] rom_bank,
  output logic                 ram_en,
  output logic [BANK_BITS-1:0] rom_bank_next,
  output logic                 ram_en_next
);

  logic        rom_wr;
  logic        nib_a;
  logic [15:0] wide_bank;
  logic [15:0] wide_new;
  logic [4:0]  b1;
  logic [3:0]  b2;
  logic [6:0]  b3;

  always_comb begin
    rom_wr    = item.wr && !item.addr[15];
    nib_a     = (item.val[3:0] == 4'hA);
    wide_bank = 16'(rom_bank);
    b1 = (item.val[4:0] == 5'd0) ? 5'd1 : item.val[4:0];
    b2 = (item.val[3:0] == 4'd0) ? 4'd1 : item.val[3:0];
    b3 = (item.val[6:0] == 7'd0) ? 7'd1 : item.val[6:0];
    wide_new      = wide_bank;
    ram_en_next   = ram_en;
    if (rom_wr) begin
      if (is_mbc1(cart_type)) begin
        case (item.addr[14:13])
          2'd0: ram_en_next = nib_a;
          2'd1: wide_new = (wide_bank & ~16'h001F) | 16'(b1);
          2'd2: wide_new = (wide_bank & ~16'h0060) | 16'({item.val[1:0], 5'd0});
          default: wide_new = wide_bank;
        endcase
      end else if (is_mbc2(cart_type)) begin
        if (!item.addr[14]) begin
          if (!item.addr[8]) begin
            ram_en_next = nib_a;
          end else begin
            wide_new = 16'(b2);
          end
        end
      end else if (is_mbc3(cart_type)) begin
        case (item.addr[14:13])
          2'd0: ram_en_next = nib_a;
          2'd1: wide_new = 16'(b3);
          default: wide_new = wide_bank;
        endcase
      end
    end
    rom_bank_next = wide_new[BANK_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank <= BANK_BITS'(1);
      ram_en   <= 1'b0;
    end else if (adv) begin
      rom_bank <= rom_bank_next;
      ram_en   <= ram_en_next;
    end
  end

endmodule

FILE: src/cbbd_decode.sv
// Bus decoder: region, echo fold, ROM address, access check, store byte and bank state.
module cbbd_decode
  import cbbd_pkg::*;
(
  input  item_t                item,
  input  logic [7:0]           cart_type,
  input  logic [BANK_BITS-1:0] rom_bank,
  input  logic                 ram_en,
  input  logic [BANK_BITS-1:0] rom_bank_next,
  input  logic                 ram_en_next,
  output result_t              res
);

  region_t                rgn;
  logic                   ok;
  logic [15:0]            loc;
  logic [20:0]            rom;
  logic [BANK_BITS+13:0]  banked;
  logic [7:0]             store;
  logic [15:0]            a;

  always_comb begin
    a      = item.addr;
    loc    = a;
    rom    = 21'd0;
    ok     = 1'b1;
    banked = {rom_bank, a[13:0]};
    if (a <= 16'h7FFF) begin
      ok = !item.wr;
      if (!a[14]) begin
        rgn = RGN_ROM0;
        if (!item.wr) rom = 21'(a);
      end else begin
        rgn = RGN_ROMX;
        if (!item.wr) rom = (cart_type != 8'd0) ? 21'(banked) : 21'(a);
      end
    end else if (a <= 16'h9FFF) begin
      rgn = RGN_VRAM;
      ok  = (item.mode != MODE_DRAWING);
    end else if (a <= 16'hBFFF) begin
      rgn = RGN_EXTRAM;
      if (item.wr) ok = ram_en;
    end else if (a <= 16'hDFFF) begin
      rgn = RGN_WRAM;
    end else if (a <= 16'hFDFF) begin
      rgn = RGN_WRAM;
      loc = a - 16'h2000;
    end else if (a <= 16'hFE9F) begin
      rgn = RGN_OAM;
      ok  = (item.mode != MODE_OAM_SCAN) && (item.mode != MODE_DRAWING);
    end else if (a <= 16'hFEFF) begin
      rgn = RGN_UNUSED;
      ok  = 1'b0;
    end else if (a <= 16'hFF7F) begin
      rgn = RGN_IO;
    end else if (a <= 16'hFFFE) begin
      rgn = RGN_HRAM;
    end else begin
      rgn = RGN_IE;
    end

    store = 8'd0;
    if (item.wr && ok) begin
      if (a == ADDR_DIV) store = 8'd0;
      else if (a == ADDR_IE) store = item.val & 8'h1F;
      else store = item.val;
    end

    res.region      = rgn;
    res.local_addr  = loc;
    res.rom_addr    = rom;
    res.allowed     = ok;
    res.store_value = store;
    res.bank_now    = 7'(rom_bank_next);
    res.ram_on      = ram_en_next;
  end

endmodule

FILE: src/cartridge_bank_and_bus_decode.sv
// Top level: input register, decode and bank update, result register.
// Each item passes the input register and then the result register on its way to the output.
// Throughput: one access per cycle unless m_tready stalls; bank state updates as an item moves to the result reg.
// Input is taken while a result waits only if the input register is empty.
// Synchronous active-high reset: both stages empty, bank 1, RAM disabled, type 0.
// Configuration writes are always ready and take effect on the next cycle.
module cartridge_bank_and_bus_decode
  import cbbd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [7:0]                cfg_data,      // cartridge_type
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [31:0]               s_tdata,       // bus_addr, write_value, video_mode, pad
  input  logic [0:0]                s_tuser,       // func
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [OUT_BYTES_BITS-1:0] m_tdata        // region, local_addr, rom_addr, allowed,
                                                   // store_value, bank_now, ram_on, pad
);

  logic [7:0]           cart_type;
  item_t                in_item;
  logic                 in_valid;
  result_t              out_res;
  result_t              res;
  logic                 adv;
  logic                 out_free;
  logic [BANK_BITS-1:0] rom_bank;
  logic [BANK_BITS-1:0] rom_bank_next;
  logic                 ram_en;
  logic                 ram_en_next;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign adv       = in_valid && out_free;
  assign s_tready  = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cart_type <= 8'd0;
    end else if (cfg_valid) begin
      cart_type <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.wr   <= s_tuser[0];
      in_item.addr <= s_tdata[15:0];
      in_item.val  <= s_tdata[23:16];
      in_item.mode <= s_tdata[25:24];
    end
  end

  cbbd_bank_ctrl u_bank (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .item          (in_item),
    .cart_type     (cart_type),
    .rom_bank      (rom_bank),
    .ram_en        (ram_en),
    .rom_bank_next (rom_bank_next),
    .ram_en_next   (ram_en_next)
  );

  cbbd_decode u_dec (
    .item          (in_item),
    .cart_type     (cart_type),
    .rom_bank      (rom_bank),
    .ram_en        (ram_en),
    .rom_bank_next (rom_bank_next),
    .ram_en_next   (ram_en_next),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= res;
    end
  end

  assign m_tdata = OUT_BYTES_BITS'(out_res);

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(rom_bank) && $stable(ram_en)))
    else $error("bank state changed without a transfer into the result register");

  a_store_needs_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_res.store_value != 8'd0)) |-> out_res.allowed)
    else $error("nonzero store byte on a blocked access");

  a_bank_shown: assert property (@(posedge clk) disable iff (rst)
    adv |=> (out_res.bank_now == 7'(rom_bank)) && (out_res.ram_on == ram_en))
    else $error("reported bank state does not match the updated state");

endmodule

FILE: test/tb_cartridge_bank_and_bus_decode.sv
// Testbench for cartridge_bank_and_bus_decode: random and directed bus accesses, scoreboard check.
module tb_cartridge_bank_and_bus_decode;
  import cbbd_pkg::*;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  localparam logic [7:0] CART_ROM_ONLY       = 8'h00;
  localparam logic [7:0] CART_MBC1           = 8'h01;
  localparam logic [7:0] CART_MBC1_RAM       = 8'h02;
  localparam logic [7:0] CART_MBC1_RAM_BATT  = 8'h03;
  localparam logic [7:0] CART_MBC2           = 8'h05;
  localparam logic [7:0] CART_MBC2_BATT      = 8'h06;
  localparam logic [7:0] CART_MBC3_TIMER     = 8'h0F;
  localparam logic [7:0] CART_MBC3_TIMER_RAM = 8'h10;
  localparam logic [7:0] CART_MBC3           = 8'h11;
  localparam logic [7:0] CART_MBC3_RAM_BATT  = 8'h13;
  localparam logic [7:0] CART_UNKNOWN        = 8'hFF;

  localparam int PHASES = 12;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int HOLD_CYCLES = 300;

  class access_ledger;
    logic [7:0]           cart_type;
    logic [BANK_BITS-1:0] rom_bank;
    logic                 ram_enable;
    result_t              pending_results[$];
    int                   mismatches;

    function new();
      cart_type  = CART_ROM_ONLY;
      rom_bank   = BANK_BITS'(1);
      ram_enable = 1'b0;
      mismatches = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void bank_control(logic [15:0] a, logic [7:0] v);
      int nb;
      nb = int'(rom_bank);
      if (cart_type >= CART_MBC1 && cart_type <= CART_MBC1_RAM_BATT) begin
        if (a <= 16'h1FFF) begin
          ram_enable = (v[3:0] == 4'hA);
        end else if (a <= 16'h3FFF) begin
          nb = (nb & ~32'h1F) | ((v[4:0] == 5'd0) ? 1 : v[4:0]);
        end else if (a <= 16'h5FFF) begin
          nb = (nb & ~32'h60) | (v[1:0] << 5);
        end
      end else if (cart_type == CART_MBC2 || cart_type == CART_MBC2_BATT) begin
        if (a <= 16'h3FFF) begin
          if (!a[8]) ram_enable = (v[3:0] == 4'hA);
          else nb = (v[3:0] == 4'd0) ? 1 : v[3:0];
        end
      end else if (cart_type >= CART_MBC3_TIMER && cart_type <= CART_MBC3_RAM_BATT) begin
        if (a <= 16'h1FFF) ram_enable = (v[3:0] == 4'hA);
        else if (a <= 16'h3FFF) nb = (v[6:0] == 7'd0) ? 1 : v[6:0];
      end
      rom_bank = nb[BANK_BITS-1:0];
    endfunction

    function void note_access(item_t it);
      result_t r;
      int rom;
      r = '0;
      r.local_addr = it.addr;
      r.allowed = 1'b1;
      if (it.addr <= 16'h7FFF) begin
        if (it.wr == FUNC_WRITE) begin
          bank_control(it.addr, it.val);
          r.allowed = 1'b0;
        end
        if (it.addr <= 16'h3FFF) begin
          r.region = RGN_ROM0;
          if (it.wr == FUNC_READ) r.rom_addr = 21'(it.addr);
        end else begin
          r.region = RGN_ROMX;
          if (it.wr == FUNC_READ) begin
            if (cart_type != CART_ROM_ONLY) begin
              rom = (int'(rom_bank) << 14) + int'(it.addr) - 32'h4000;
              r.rom_addr = rom[20:0];
            end else begin
              r.rom_addr = 21'(it.addr);
            end
          end
        end
      end else if (it.addr <= 16'h9FFF) begin
        r.region = RGN_VRAM;
        r.allowed = (it.mode != MODE_DRAWING);
      end else if (it.addr <= 16'hBFFF) begin
        r.region = RGN_EXTRAM;
        if (it.wr == FUNC_WRITE) r.allowed = ram_enable;
      end else if (it.addr <= 16'hDFFF) begin
        r.region = RGN_WRAM;
      end else if (it.addr <= 16'hFDFF) begin
        r.region = RGN_WRAM;
        r.local_addr = it.addr - 16'h2000;
      end else if (it.addr <= 16'hFE9F) begin
        r.region = RGN_OAM;
        r.allowed = (it.mode != MODE_OAM_SCAN && it.mode != MODE_DRAWING);
      end else if (it.addr <= 16'hFEFF) begin
        r.region = RGN_UNUSED;
        r.allowed = 1'b0;
      end else if (it.addr <= 16'hFF7F) begin
        r.region = RGN_IO;
      end else if (it.addr <= 16'hFFFE) begin
        r.region = RGN_HRAM;
      end else begin
        r.region = RGN_IE;
      end
      if (it.wr == FUNC_WRITE && r.allowed) begin
        if (it.addr == ADDR_DIV) r.store_value = 8'h00;
        else if (it.addr == ADDR_IE) r.store_value = it.val & 8'h1F;
        else r.store_value = it.val;
      end
      r.bank_now = 7'(rom_bank);
      r.ram_on = ram_enable;
      pending_results.push_back(r);
    endfunction

    function string fields(result_t r);
      return $sformatf("region=%0d local=%h rom=%h allowed=%b store=%h bank=%h ram_on=%b",
                       r.region, r.local_addr, r.rom_addr, r.allowed, r.store_value,
                       r.bank_now, r.ram_on);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", fields(got));
        return;
      end
      want = pending_results.pop_front();
      if (got.region !== want.region || got.local_addr !== want.local_addr ||
          got.rom_addr !== want.rom_addr || got.allowed !== want.allowed ||
          got.store_value !== want.store_value || got.bank_now !== want.bank_now ||
          got.ram_on !== want.ram_on) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at %0t\n  expected %s\n  actual   %s", $time,
                   fields(want), fields(got));
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [0:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [OUT_BYTES_BITS-1:0] m_tdata;

  access_ledger ledger;
  int send_idle = 0;
  int recv_idle = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int hold_left = 0;
  logic [15:0] boundary_addrs [0:25];
  logic [7:0]  phase_types [0:PHASES-1];

  cartridge_bank_and_bus_decode dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (holds_done != holds_asked) begin
      holds_done = holds_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        ledger.note_access('{wr: s_tuser[0], addr: s_tdata[15:0], val: s_tdata[23:16],
                             mode: s_tdata[25:24]});
      end
      if (cfg_valid && cfg_ready) ledger.cart_type = cfg_data;
      if (m_tvalid && m_tready) ledger.check_result(result_t'(m_tdata[OUT_BITS-1:0]));
    end
  end

  function automatic item_t access(logic wr, logic [15:0] a, logic [7:0] v, logic [1:0] m);
    item_t it;
    it.wr = wr;
    it.addr = a;
    it.val = v;
    it.mode = m;
    return it;
  endfunction

  function automatic item_t random_access();
    item_t it;
    int pick;
    pick = $urandom_range(0, 9);
    it = access(1'($urandom_range(0, 1)), 16'($urandom_range(0, 16'hFFFF)),
                8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
    if (pick <= 3) begin
      // controller writes, biased toward enable codes and zero banks
      it.wr = FUNC_WRITE;
      it.addr = 16'($urandom_range(0, 16'h7FFF));
      case ($urandom_range(0, 3))
        0: it.val[3:0] = 4'hA;
        1: it.val = it.val & 8'h80;
        default: ;
      endcase
    end else if (pick <= 5) begin
      it.wr = FUNC_READ;
      it.addr = 16'($urandom_range(0, 16'h7FFF));
    end else if (pick == 6) begin
      it.addr = 16'($urandom_range(16'hA000, 16'hBFFF));
    end else if (pick == 7) begin
      it.addr = boundary_addrs[5'($urandom_range(0, 25))];
    end
    return it;
  endfunction

  task automatic send_access(item_t it);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, it.mode, it.val, it.addr};
    s_tuser <= it.wr;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cart_type(logic [7:0] t);
    cfg_valid <= 1'b1;
    cfg_data <= t;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  task automatic run_directed(logic [7:0] t);
    case (t)
      CART_ROM_ONLY: begin
        send_access(access(FUNC_READ,  16'h4000, 8'h00, 2'd0));
        send_access(access(FUNC_READ,  16'h8000, 8'h00, MODE_DRAWING));
        send_access(access(FUNC_WRITE, 16'h9FFF, 8'hFF, MODE_OAM_SCAN));
        send_access(access(FUNC_READ,  16'hFE00, 8'h00, MODE_OAM_SCAN));
        send_access(access(FUNC_WRITE, 16'hFE9F, 8'h5A, 2'd1));
        send_access(access(FUNC_READ,  16'hFEA0, 8'h00, 2'd0));
        send_access(access(FUNC_WRITE, 16'hFEFF, 8'hFF, 2'd0));
        send_access(access(FUNC_WRITE, ADDR_DIV, 8'hFF, 2'd0));
        send_access(access(FUNC_WRITE, ADDR_IE,  8'hFF, 2'd3));
        send_access(access(FUNC_READ,  16'hFF80, 8'h00, 2'd0));
        send_access(access(FUNC_WRITE, 16'hFFFE, 8'h00, 2'd0));
        send_access(access(FUNC_READ,  16'hE000, 8'h00, 2'd0));
        send_access(access(FUNC_WRITE, 16'hFDFF, 8'hA5, 2'd2));
        send_access(access(FUNC_WRITE, 16'hA000, 8'h12, 2'd0));
      end
      CART_MBC1: begin
        send_access(access(FUNC_WRITE, 16'h0000, 8'h0A, 2'd0));
        send_access(access(FUNC_WRITE, 16'hA000, 8'h34, 2'd3));
        send_access(access(FUNC_WRITE, 16'h2000, 8'h00, 2'd0));
        send_access(access(FUNC_WRITE, 16'h3FFF, 8'hFF, 2'd0));
        send_access(access(FUNC_WRITE, 16'h4000, 8'hFF, 2'd0));
        send_access(access(FUNC_READ,  16'h7FFF, 8'h00, 2'd0));
        send_access(access(FUNC_WRITE, 16'h6000, 8'h01, 2'd0));
        send_access(access(FUNC_WRITE, 16'h1FFF, 8'h00, 2'd0));
      end
      CART_MBC2: begin
        send_access(access(FUNC_WRITE, 16'h0100, 8'h00, 2'd0));
        send_access(access(FUNC_WRITE, 16'h00FF, 8'h1A, 2'd0));
        send_access(access(FUNC_WRITE, 16'h3F00, 8'hFF, 2'd0));
      end
      CART_MBC3_TIMER: begin
        send_access(access(FUNC_WRITE, 16'h2000, 8'h80, 2'd0));
        send_access(access(FUNC_WRITE, 16'h3FFF, 8'h7F, 2'd0));
        send_access(access(FUNC_WRITE, 16'h1FFF, 8'h0A, 2'd0));
      end
      default: ;
    endcase
  endtask

  initial begin
    #4_000_000;
    $display("FAIL cartridge_bank_and_bus_decode");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data <= 8'h00;
    s_tvalid <= 1'b0;
    s_tdata <= 32'd0;
    s_tuser <= 1'b0;
    ledger = new();
    boundary_addrs = '{16'h0000, 16'h1FFF, 16'h2000, 16'h3FFF, 16'h4000, 16'h5FFF,
                       16'h6000, 16'h7FFF, 16'h8000, 16'h9FFF, 16'hA000, 16'hBFFF,
                       16'hC000, 16'hDFFF, 16'hE000, 16'hFDFF, 16'hFE00, 16'hFE9F,
                       16'hFEA0, 16'hFEFF, 16'hFF00, 16'hFF04, 16'hFF7F, 16'hFF80,
                       16'hFFFE, 16'hFFFF};
    phase_types = '{CART_ROM_ONLY, CART_MBC1, CART_MBC2, CART_MBC3_TIMER, CART_MBC1_RAM,
                    CART_MBC2_BATT, CART_MBC3_RAM_BATT, CART_UNKNOWN, CART_MBC1_RAM_BATT,
                    CART_MBC3, CART_ROM_ONLY, CART_MBC3_TIMER_RAM};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      if (p < 4) begin
        send_idle = 14;
        recv_idle = 60;
      end else if (p < 8) begin
        send_idle = 60;
        recv_idle = 14;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (p == 10) phase_types[p] = 8'($urandom_range(0, 8'h14));
      write_cart_type(phase_types[p]);
      if (p < 4) run_directed(phase_types[p]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 2 && n == 40) holds_asked = holds_asked + 1;
        if (p == 5 && n == 80) drain();
        send_access(random_access());
      end
      drain();
    end
    repeat (8) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("PASS cartridge_bank_and_bus_decode");
    end else begin
      $display("FAIL cartridge_bank_and_bus_decode");
    end
    $finish;
  end

endmodule

FILE: cartridge_bank_and_bus_decode.f
src/cbbd_pkg.sv
src/cbbd_bank_ctrl.sv
src/cbbd_decode.sv
src/cartridge_bank_and_bus_decode.sv
test/tb_cartridge_bank_and_bus_decode.sv
